// ===== hdl/tcpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared codes and controller/datapath link types for the tiny register core.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  // request modes
  localparam logic [1:0] MODE_LOAD_WORD = 2'd0;
  localparam logic [1:0] MODE_RESTART   = 2'd1;
  localparam logic [1:0] MODE_EXEC      = 2'd2;

  // opcodes
  localparam logic [3:0] OPC_LOAD      = 4'd0;
  localparam logic [3:0] OPC_STORE     = 4'd1;
  localparam logic [3:0] OPC_MOVREG    = 4'd2;
  localparam logic [3:0] OPC_MOVIMM    = 4'd3;
  localparam logic [3:0] OPC_ADDREG    = 4'd4;
  localparam logic [3:0] OPC_ADDIMM    = 4'd5;
  localparam logic [3:0] OPC_SUBREG    = 4'd6;
  localparam logic [3:0] OPC_SUBIMM    = 4'd7;
  localparam logic [3:0] OPC_MULREG    = 4'd8;
  localparam logic [3:0] OPC_MULIMM    = 4'd9;
  localparam logic [3:0] OPC_CMP       = 4'd10;
  localparam logic [3:0] OPC_BLE       = 4'd11;
  localparam logic [3:0] OPC_BAL       = 4'd12;
  localparam logic [3:0] OPC_PRINTINT  = 4'd13;
  localparam logic [3:0] OPC_PRINTCHAR = 4'd14;

  localparam logic [31:0] HALT_WORD = 32'h0F00_0000;

  // controller -> datapath
  typedef struct packed {
    logic latch_req;    // request accepted, capture payload
    logic fetch;        // program store read at pc
    logic decode;       // register file read, data store read
    logic exec_commit;  // instruction retires
    logic req_commit;   // non-execute request, or execute while halted, retires
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic halted;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== hdl/tiny_register_cpu_core_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_register_cpu_core_unit
// Four-register 32-bit core: program load, restart and single-step execute
// requests, one result per request carrying pc, halt and print output.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Payload
// in_      in   in_valid/in_ready     mode, address, instruction_word
// out_     out  out_valid/out_ready   pc, halted, print_valid/is_char/value
//
// Execute request: program store read, then register/data store read, then
// execute and retire. Other requests, and execute while halted, retire
// without the store reads. A retire waits while the result register is full.
// One request in flight; the next is taken as soon as the previous retires
// into the result register, even while that result waits for out_ready.
// Reset clears pc, flags, registers and store valid bits.
// ----------------------------------------------------------------------------
module tiny_register_cpu_core_unit
  import tcpu_pkg::*;
#(
  parameter int DATA_WORDS    = 256,
  parameter int PROGRAM_WORDS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [7:0]         in_address,
  input  wire logic [31:0]        in_instruction_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_pc,
  output logic                    out_halted,
  output logic                    out_print_valid,
  output logic                    out_print_is_char,
  output logic signed [31:0]      out_print_value
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tcpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcpu_dpath #(
    .DATA_WORDS    (DATA_WORDS),
    .PROGRAM_WORDS (PROGRAM_WORDS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_instruction_word (in_instruction_word),
    .out_pc              (out_pc),
    .out_halted          (out_halted),
    .out_print_valid     (out_print_valid),
    .out_print_is_char   (out_print_is_char),
    .out_print_value     (out_print_value)
  );

endmodule
`default_nettype wire

// ===== hdl/tcpu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_ctrl
// Sequencer: request acceptance, fetch/decode/execute steps, result register
// handshake.
// ----------------------------------------------------------------------------
module tcpu_ctrl
  import tcpu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_mode,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire ctrl_sts_t  sts,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_req = 1'b1;
          if (in_mode == MODE_EXEC && !sts.halted) begin
            cmd.fetch = 1'b1;
            state_nxt = S_DEC;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.req_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.exec_commit || cmd.req_commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result never overwrites one still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_commit || cmd.req_commit) |-> out_free)
    else $error("commit while result register busy");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fetch, cmd.decode, cmd.exec_commit, cmd.req_commit}))
    else $error("overlapping datapath commands");

  a_exec_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC) |=> (state_r == S_EXEC))
    else $error("decode not followed by execute");

endmodule
`default_nettype wire

// ===== hdl/tcpu_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpu_dpath
// Architectural state, program and data stores, register file, ALU and
// result register.
// ----------------------------------------------------------------------------
module tcpu_dpath
  import tcpu_pkg::*;
#(
  parameter int DATA_WORDS    = 256,
  parameter int PROGRAM_WORDS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts,
  input  wire logic [1:0]         in_mode,
  input  wire logic [7:0]         in_address,
  input  wire logic [31:0]        in_instruction_word,
  output logic [7:0]              out_pc,
  output logic                    out_halted,
  output logic                    out_print_valid,
  output logic                    out_print_is_char,
  output logic signed [31:0]      out_print_value
);

  localparam int PA_W = $clog2(PROGRAM_WORDS);
  localparam int DA_W = $clog2(DATA_WORDS);

  // captured request
  logic [1:0]  req_mode_r;
  logic [7:0]  req_addr_r;
  logic [31:0] req_word_r;

  // architectural state
  logic [7:0]  pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic        le_r, le_nxt;
  logic [31:0] gpr_r [4];

  // stores
  logic [31:0]              pmem [PROGRAM_WORDS];
  logic [PROGRAM_WORDS-1:0] pvld_r;
  logic [31:0]              prd_r;
  logic                     phit_r;
  logic [31:0]              dmem [DATA_WORDS];
  logic [DATA_WORDS-1:0]    dvld_r;
  logic [31:0]              drd_r;
  logic                     dhit_r;

  // operands read in the decode step
  logic [31:0] va_r, vb_r;

  logic [31:0] ir;
  logic [3:0]  opc;
  logic [1:0]  rd, ra, rb;
  logic [7:0]  imm;
  logic [31:0] imm_ext;
  logic [7:0]  pc_inc;

  logic        pc_in_range, pw_in_range, imm_in_range;
  logic [PA_W-1:0] pc_idx, pw_idx;
  logic [DA_W-1:0] imm_idx;

  logic        gpr_we;
  logic [31:0] gpr_wd;
  logic        pmem_we, dmem_we;
  logic        pv, pch;
  logic [31:0] pval;
  logic        commit;

  assign sts.halted = halt_r;
  assign commit     = cmd.exec_commit || cmd.req_commit;

  // fetch beyond the program store or of an unwritten word reads as halt
  assign ir      = phit_r ? prd_r : HALT_WORD;
  assign opc     = ir[27:24];
  assign rd      = ir[17:16];
  assign ra      = ir[9:8];
  assign rb      = ir[1:0];
  assign imm     = ir[7:0];
  assign imm_ext = {24'd0, imm};
  assign pc_inc  = pc_r + 8'd1;

  assign pc_in_range  = ({1'b0, pc_r} < 9'(PROGRAM_WORDS));
  assign pw_in_range  = ({1'b0, req_addr_r} < 9'(PROGRAM_WORDS));
  assign imm_in_range = ({1'b0, imm} < 9'(DATA_WORDS));
  assign pc_idx       = pc_r[PA_W-1:0];
  assign pw_idx       = req_addr_r[PA_W-1:0];
  assign imm_idx      = imm[DA_W-1:0];

  always_comb begin
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    le_nxt   = le_r;
    gpr_we   = 1'b0;
    gpr_wd   = '0;
    pmem_we  = 1'b0;
    dmem_we  = 1'b0;
    pv       = 1'b0;
    pch      = 1'b0;
    pval     = '0;
    if (cmd.req_commit) begin
      unique case (req_mode_r)
        MODE_LOAD_WORD: pmem_we = pw_in_range;
        MODE_RESTART: begin
          pc_nxt   = 8'd0;
          halt_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd.exec_commit) begin
      pc_nxt = pc_inc;
      unique case (opc)
        OPC_LOAD: begin
          gpr_we = 1'b1;
          gpr_wd = dhit_r ? drd_r : 32'd0;
        end
        OPC_STORE:  dmem_we = imm_in_range;
        OPC_MOVREG: begin
          gpr_we = 1'b1;
          gpr_wd = va_r;
        end
        OPC_MOVIMM: begin
          gpr_we = 1'b1;
          gpr_wd = imm_ext;
        end
        OPC_ADDREG: begin
          gpr_we = 1'b1;
          gpr_wd = va_r + vb_r;
        end
        OPC_ADDIMM: begin
          gpr_we = 1'b1;
          gpr_wd = va_r + imm_ext;
        end
        OPC_SUBREG: begin
          gpr_we = 1'b1;
          gpr_wd = va_r - vb_r;
        end
        OPC_SUBIMM: begin
          gpr_we = 1'b1;
          gpr_wd = va_r - imm_ext;
        end
        OPC_MULREG: begin
          gpr_we = 1'b1;
          gpr_wd = va_r * vb_r;
        end
        OPC_MULIMM: begin
          gpr_we = 1'b1;
          gpr_wd = va_r * imm_ext;
        end
        OPC_CMP:    le_nxt = ($signed(va_r) <= $signed(vb_r));
        OPC_BLE: begin
          if (le_r) pc_nxt = imm;
        end
        OPC_BAL:    pc_nxt = imm;
        OPC_PRINTINT: begin
          pv   = 1'b1;
          pval = va_r;
        end
        OPC_PRINTCHAR: begin
          pv   = 1'b1;
          pch  = 1'b1;
          pval = {24'd0, va_r[7:0]};
        end
        default:    halt_nxt = 1'b1;
      endcase
    end
  end

  // control state and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= 8'd0;
      halt_r <= 1'b0;
      le_r   <= 1'b0;
      pvld_r <= '0;
      dvld_r <= '0;
      for (int i = 0; i < 4; i++) gpr_r[i] <= '0;
    end else begin
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
      le_r   <= le_nxt;
      if (pmem_we) pvld_r[pw_idx] <= 1'b1;
      if (dmem_we) dvld_r[imm_idx] <= 1'b1;
      if (gpr_we) gpr_r[rd] <= gpr_wd;
    end
  end

  // request capture, read registers, result register
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_mode_r <= in_mode;
      req_addr_r <= in_address;
      req_word_r <= in_instruction_word;
    end
    if (cmd.decode) begin
      va_r <= gpr_r[ra];
      vb_r <= gpr_r[rb];
    end
    if (commit) begin
      out_pc            <= pc_nxt;
      out_halted        <= halt_nxt;
      out_print_valid   <= pv;
      out_print_is_char <= pch;
      out_print_value   <= pval;
    end
  end

  // program store
  always_ff @(posedge clk) begin
    if (pmem_we) pmem[pw_idx] <= req_word_r;
    if (cmd.fetch) begin
      prd_r  <= pmem[pc_idx];
      phit_r <= pc_in_range && pvld_r[pc_idx];
    end
  end

  // data store
  always_ff @(posedge clk) begin
    if (dmem_we) dmem[imm_idx] <= va_r;
    if (cmd.decode) begin
      drd_r  <= dmem[imm_idx];
      dhit_r <= imm_in_range && dvld_r[imm_idx];
    end
  end

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(pc_r))
    else $error("pc moved without a commit");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && !(cmd.req_commit && req_mode_r == MODE_RESTART)) |=> halt_r)
    else $error("halt cleared without restart");

  a_no_exec_halted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> !halt_r)
    else $error("fetch while halted");

endmodule
`default_nettype wire

// ===== tb/sv/tcpu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpu_checker
// Watches both channels of the tiny register core, runs its own model of the
// core on every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module tcpu_checker
  import tcpu_pkg::*;
#(
  parameter int DATA_WORDS    = 256,
  parameter int PROGRAM_WORDS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_address,
  input  logic [31:0]        in_instruction_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_pc,
  input  logic               out_halted,
  input  logic               out_print_valid,
  input  logic               out_print_is_char,
  input  logic signed [31:0] out_print_value,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic [7:0]  pc;
    logic        halted;
    logic        print_valid;
    logic        print_is_char;
    logic [31:0] print_value;
  } core_result_t;

  // model state
  logic [31:0] gpr [4];
  logic [7:0]  pc_q;
  logic        le_q;
  logic        halt_q;
  logic [31:0] data_mem [DATA_WORDS];
  logic [31:0] prog_mem [PROGRAM_WORDS];

  core_result_t expected_results[$];
  int n_fail    = 0;
  int n_waiting = 0;

  assign fail_count  = n_fail;
  assign outstanding = n_waiting;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    n_fail++;
  endtask

  function automatic core_result_t retire_request(input logic [1:0] mode,
                                                  input logic [7:0] addr,
                                                  input logic [31:0] word);
    core_result_t r;
    logic [31:0]  insn;
    logic [31:0]  va;
    logic [31:0]  vb;
    logic [3:0]   opc;
    logic [1:0]   rd;
    logic [7:0]   imm;
    r = '0;
    case (mode)
      MODE_LOAD_WORD: begin
        if (addr < PROGRAM_WORDS) prog_mem[addr] = word;
      end
      MODE_RESTART: begin
        pc_q   = 8'd0;
        halt_q = 1'b0;
      end
      MODE_EXEC: begin
        if (!halt_q) begin
          insn = (pc_q < PROGRAM_WORDS) ? prog_mem[pc_q] : HALT_WORD;
          opc  = insn[27:24];
          rd   = insn[17:16];
          imm  = insn[7:0];
          va   = gpr[insn[9:8]];
          vb   = gpr[insn[1:0]];
          pc_q = pc_q + 8'd1;
          case (opc)
            OPC_LOAD:      gpr[rd] = (imm < DATA_WORDS) ? data_mem[imm] : 32'd0;
            OPC_STORE: begin
              if (imm < DATA_WORDS) data_mem[imm] = va;
            end
            OPC_MOVREG:    gpr[rd] = va;
            OPC_MOVIMM:    gpr[rd] = {24'd0, imm};
            OPC_ADDREG:    gpr[rd] = va + vb;
            OPC_ADDIMM:    gpr[rd] = va + {24'd0, imm};
            OPC_SUBREG:    gpr[rd] = va - vb;
            OPC_SUBIMM:    gpr[rd] = va - {24'd0, imm};
            OPC_MULREG:    gpr[rd] = va * vb;
            OPC_MULIMM:    gpr[rd] = va * {24'd0, imm};
            OPC_CMP:       le_q = ($signed(va) <= $signed(vb));
            OPC_BLE: begin
              if (le_q) pc_q = imm;
            end
            OPC_BAL:       pc_q = imm;
            OPC_PRINTINT: begin
              r.print_valid = 1'b1;
              r.print_value = va;
            end
            OPC_PRINTCHAR: begin
              r.print_valid   = 1'b1;
              r.print_is_char = 1'b1;
              r.print_value   = {24'd0, va[7:0]};
            end
            default:       halt_q = 1'b1;
          endcase
        end
      end
      default: ;  // unused mode leaves everything alone
    endcase
    r.pc     = pc_q;
    r.halted = halt_q;
    return r;
  endfunction

  always @(posedge clk) begin
    core_result_t want;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      foreach (prog_mem[i]) prog_mem[i] = HALT_WORD;
      pc_q   = 8'd0;
      le_q   = 1'b0;
      halt_q = 1'b0;
      expected_results.delete();
      n_waiting <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result pc", {24'd0, out_pc}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_pc !== want.pc)
            report_mismatch("pc", {24'd0, out_pc}, {24'd0, want.pc});
          if (out_halted !== want.halted)
            report_mismatch("halted", {31'd0, out_halted}, {31'd0, want.halted});
          if (out_print_valid !== want.print_valid)
            report_mismatch("print_valid", {31'd0, out_print_valid},
                            {31'd0, want.print_valid});
          if (out_print_is_char !== want.print_is_char)
            report_mismatch("print_is_char", {31'd0, out_print_is_char},
                            {31'd0, want.print_is_char});
          if (out_print_value !== want.print_value)
            report_mismatch("print_value", out_print_value, want.print_value);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(retire_request(in_mode, in_address,
                                                  in_instruction_word));
      n_waiting <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives program load, restart and execute requests into the tiny register
// core with random idling on both channels; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import tcpu_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [3:0] OPC_HALT       = 4'd15;
  localparam int         RANDOM_ITEMS   = 1100;
  localparam int         LONG_HOLD      = 400;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 8;

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               in_valid            = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode             = MODE_LOAD_WORD;
  logic [7:0]         in_address          = 8'd0;
  logic [31:0]        in_instruction_word = 32'd0;
  logic               out_valid;
  logic               out_ready           = 1'b0;
  logic [7:0]         out_pc;
  logic               out_halted;
  logic               out_print_valid;
  logic               out_print_is_char;
  logic signed [31:0] out_print_value;

  int fail_count;
  int outstanding;
  int sent        = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;  // no idling on either side while set
  bit squeeze     = 1'b0;  // asks the receiver for one long hold-off

  tiny_register_cpu_core_unit dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_address, .in_instruction_word,
    .out_valid, .out_ready, .out_pc, .out_halted,
    .out_print_valid, .out_print_is_char, .out_print_value
  );

  tcpu_checker chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_address, .in_instruction_word,
    .out_valid, .out_ready, .out_pc, .out_halted,
    .out_print_valid, .out_print_is_char, .out_print_value,
    .fail_count, .outstanding
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // unused bits of the upper three bytes get random content
  function automatic logic [31:0] pack_insn(input logic [3:0] opc, input logic [1:0] rd,
                                            input logic [1:0] ra, input logic [7:0] low);
    return {4'($urandom), opc, 6'($urandom), rd, 6'($urandom), ra, low};
  endfunction

  function automatic logic [31:0] rand_insn(input int len);
    logic [3:0] opc;
    logic [7:0] low;
    int         r;
    r   = $urandom_range(0, 99);
    opc = (r < 3) ? OPC_HALT : 4'($urandom_range(0, 14));
    low = 8'($urandom);
    r   = $urandom_range(0, 99);
    case (opc)
      OPC_BLE, OPC_BAL: begin
        // keep most branches inside the program
        if (r < 90) low = 8'($urandom_range(0, len - 1));
      end
      OPC_LOAD, OPC_STORE: begin
        if (r < 70) low = 8'($urandom_range(0, 7));
        else if (r < 90) low = 8'($urandom_range(248, 255));
      end
      default: ;
    endcase
    return pack_insn(opc, 2'($urandom), 2'($urandom), low);
  endfunction

  task automatic send_req(input logic [1:0] mode, input logic [7:0] addr,
                          input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_address          <= addr;
    in_instruction_word <= word;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_exec();
    send_req(MODE_EXEC, 8'($urandom), $urandom);
  endtask

  task automatic send_noise(input int len);
    case ($urandom_range(0, 3))
      0:       send_req(MODE_UNUSED, 8'($urandom), $urandom);
      1:       send_req(MODE_LOAD_WORD, 8'($urandom), $urandom);
      2:       send_req(MODE_LOAD_WORD, 8'($urandom_range(0, len - 1)), rand_insn(len));
      default: send_req(MODE_RESTART, 8'($urandom), $urandom);
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // receiver: bursts of ready with random stalls, one long hold-off on request
  initial begin
    int burst;
    int stall;
    bit squeezed;
    squeezed = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      burst = calm ? $urandom_range(20, 60) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0]  demo_addr [13];
    logic [31:0] demo_word [13];
    int          len;
    int          steps;
    int          prog;

    // short program touching most opcodes, a skipped all-ones word and pc wrap
    demo_addr = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
                  8'd10, 8'd11, 8'd255};
    demo_word[0]  = pack_insn(OPC_MOVIMM,    2'd0, 2'd0, 8'hFF);
    demo_word[1]  = pack_insn(OPC_SUBIMM,    2'd1, 2'd2, 8'h01);  // r1 = -1
    demo_word[2]  = pack_insn(OPC_PRINTINT,  2'd0, 2'd1, 8'h00);
    demo_word[3]  = pack_insn(OPC_PRINTCHAR, 2'd0, 2'd0, 8'h00);
    demo_word[4]  = pack_insn(OPC_STORE,     2'd0, 2'd1, 8'hFF);
    demo_word[5]  = pack_insn(OPC_LOAD,      2'd3, 2'd0, 8'hFF);
    demo_word[6]  = pack_insn(OPC_MULREG,    2'd2, 2'd3, 8'h00);
    demo_word[7]  = pack_insn(OPC_ADDREG,    2'd2, 2'd2, 8'h00);
    demo_word[8]  = pack_insn(OPC_CMP,       2'd0, 2'd1, 8'h02);
    demo_word[9]  = pack_insn(OPC_BLE,       2'd0, 2'd0, 8'd11);
    demo_word[10] = 32'hFFFF_FFFF;
    demo_word[11] = pack_insn(OPC_BAL,       2'd0, 2'd0, 8'hFF);
    demo_word[12] = pack_insn(OPC_MULIMM,    2'd3, 2'd1, 8'hFF);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_exec();  // fresh program store is all halt words
    send_exec();  // halted: no change
    send_req(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_req(MODE_RESTART, 8'h00, 32'h0000_0000);
    for (int i = 0; i < 13; i++) send_req(MODE_LOAD_WORD, demo_addr[i], demo_word[i]);
    repeat (13) send_exec();  // ends after the wrap back to address 0
    wait_drained();

    sent = 0;
    prog = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 24);
      for (int i = 0; i < len; i++) send_req(MODE_LOAD_WORD, 8'(i), rand_insn(len));
      repeat ($urandom_range(0, 2)) send_noise(len);
      send_req(MODE_RESTART, 8'($urandom), $urandom);
      if (prog == 2) squeeze = 1'b1;
      steps = $urandom_range(10, 60);
      repeat (steps) begin
        if ($urandom_range(0, 39) == 0) send_noise(len);
        else send_exec();
      end
      if (prog == 6) wait_drained();
      prog++;
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tcpu_pkg.sv
hdl/tcpu_ctrl.sv
hdl/tcpu_dpath.sv
hdl/tiny_register_cpu_core_unit.sv
tb/sv/tcpu_checker.sv
tb/sv/tb_top.sv
